>>> hdl/vec3_normalize_unit_cross_core_assert.svh
// Assertion macros used by the vector normalizer core RTL.
`ifndef VEC3_NORMALIZE_UNIT_CROSS_CORE_ASSERT_SVH
`define VEC3_NORMALIZE_UNIT_CROSS_CORE_ASSERT_SVH

// Check cons in the same cycle as ante.
`define VNU_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("vnu assertion failed");

// Check cons in the cycle after ante.
`define VNU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("vnu assertion failed");

`endif

>>> hdl/vnu_pkg.sv
package vnu_pkg;

    localparam int IN_W       = 24;
    localparam int HALF_W     = 24;
    localparam int PROD_W     = 48;
    localparam int VEC_W      = 49;
    localparam int MAG_W      = 48;
    localparam int SQ_W       = 96;
    localparam int RAD_W      = 98;
    localparam int ROOT_W     = 49;
    localparam int REM_W      = 50;
    localparam int SQRT_STEPS = 49;
    localparam int LEN_W      = 33;
    localparam int LEN_SHIFT  = 16;
    localparam int MIN_W      = 16;
    localparam int Q_W        = 31;
    localparam int DIV_STEPS  = 31;
    localparam int OUT_W      = 32;
    localparam int LANES      = 3;

    typedef struct packed {
        logic                     func;
        logic signed [IN_W-1:0]   ax;
        logic signed [IN_W-1:0]   ay;
        logic signed [IN_W-1:0]   az;
        logic signed [IN_W-1:0]   bx;
        logic signed [IN_W-1:0]   by;
        logic signed [IN_W-1:0]   bz;
    } t_in;

    typedef struct packed {
        logic signed [OUT_W-1:0]  ux;
        logic signed [OUT_W-1:0]  uy;
        logic signed [OUT_W-1:0]  uz;
        logic [LEN_W-1:0]         vec_length;
        logic                     degenerate;
    } t_out;

    typedef struct packed {
        logic [LANES-1:0]             neg;
        logic [LANES-1:0][MAG_W-1:0]  mag;
    } t_side;

    typedef struct packed {
        logic [LANES-1:0]   neg;
        logic [LEN_W-1:0]   len_q16;
        logic               degen;
    } t_info;

endpackage

>>> hdl/vec3_normalize_unit_cross_core.sv
// Three-component vector normalizer.
// Input channel (i_in_valid / o_in_stall / i_in_data): one transaction per
// vector pair; func selects vector a or the cross product a x b.
// Output channel (o_out_valid / i_out_stall / o_out_data): one transaction per
// input transaction, in order: unit vector in Q1.30, length in Q17.16 and a
// degenerate flag.
// Configuration: i_cfg_we writes i_cfg_wdata into the min_length threshold;
// write only while no transaction is in flight.
// The pipeline has stages for products, squares and sum, the bitwise
// square root (one result bit per stage), the threshold compare, the
// restoring divider (one quotient bit per stage) and an output register.
// Throughput is one transaction per cycle while the pipeline is not held.
// Reset clears all valid bits and sets min_length to 0.
// While the output register holds a transaction and i_out_stall is high, the
// whole pipeline holds and o_in_stall is high; nothing is lost or repeated.
`include "vec3_normalize_unit_cross_core_assert.svh"

module vec3_normalize_unit_cross_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  vnu_pkg::t_in                i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output vnu_pkg::t_out               o_out_data,
    input  logic                        i_cfg_we,
    input  logic [vnu_pkg::MIN_W-1:0]   i_cfg_wdata
);
    import vnu_pkg::*;

    logic                           en;
    logic [MIN_W-1:0]               r_min;

    logic                           fr_valid;
    logic [RAD_W-1:0]               fr_rad;
    t_side                          fr_side;

    logic                           sq_valid;
    logic [ROOT_W-1:0]              sq_root;
    t_side                          sq_side;

    logic                           r_mid_vld;
    logic [ROOT_W-1:0]              r_mid_len;
    logic [LANES-1:0][MAG_W-1:0]    r_mid_mag;
    t_info                          r_mid_info;
    t_info                          n_mid_info;

    logic                           dv_valid;
    logic [LANES-1:0][Q_W-1:0]      dv_quo;
    t_info                          dv_info;

    logic                           r_out_vld;
    t_out                           r_out_data;
    t_out                           n_out_data;
    logic [LANES-1:0][OUT_W-1:0]    n_comp;
    logic [LANES-1:0][OUT_W-1:0]    n_uq;

    assign en         = !(r_out_vld && i_out_stall);
    assign o_in_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= '0;
        end else if (i_cfg_we) begin
            r_min <= i_cfg_wdata;
        end
    end

    vnu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .o_valid (fr_valid),
        .o_rad   (fr_rad),
        .o_side  (fr_side)
    );

    vnu_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (fr_valid),
        .i_rad   (fr_rad),
        .i_side  (fr_side),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    always_comb begin
        n_mid_info.neg     = sq_side.neg;
        n_mid_info.len_q16 = sq_root[ROOT_W-1:LEN_SHIFT];
        n_mid_info.degen   = (sq_root[ROOT_W-1:LEN_SHIFT] <= {{(LEN_W-MIN_W){1'b0}}, r_min});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_vld <= 1'b0;
        end else if (en) begin
            r_mid_vld <= sq_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mid_len  <= sq_root;
            r_mid_mag  <= sq_side.mag;
            r_mid_info <= n_mid_info;
        end
    end

    vnu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_mid_vld),
        .i_len   (r_mid_len),
        .i_mag   (r_mid_mag),
        .i_info  (r_mid_info),
        .o_valid (dv_valid),
        .o_quo   (dv_quo),
        .o_info  (dv_info)
    );

    always_comb begin
        for (int j = 0; j < LANES; j++) begin
            n_uq[j]   = {{(OUT_W-Q_W){1'b0}}, dv_quo[j]};
            n_comp[j] = dv_info.degen ? '0 : (dv_info.neg[j] ? (-n_uq[j]) : n_uq[j]);
        end
        n_out_data.ux         = n_comp[0];
        n_out_data.uy         = n_comp[1];
        n_out_data.uz         = n_comp[2];
        n_out_data.vec_length = dv_info.degen ? '0 : dv_info.len_q16;
        n_out_data.degenerate = dv_info.degen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_data;

    `VNU_ASSERT_IMPL(a_degen_zero, o_out_valid && o_out_data.degenerate, o_out_data.vec_length == '0 && o_out_data.ux == '0 && o_out_data.uy == '0 && o_out_data.uz == '0)
    `VNU_ASSERT_IMPL(a_len_above_min, o_out_valid && !o_out_data.degenerate, o_out_data.vec_length > {{(LEN_W-MIN_W){1'b0}}, r_min})
    `VNU_ASSERT_IMPL(a_unit_range, o_out_valid, o_out_data.ux <= 32'sh4000_0000 && o_out_data.ux >= -32'sh4000_0000 && o_out_data.uy <= 32'sh4000_0000 && o_out_data.uy >= -32'sh4000_0000 && o_out_data.uz <= 32'sh4000_0000 && o_out_data.uz >= -32'sh4000_0000)
    `VNU_ASSERT_NEXT(a_hold_on_stall, o_out_valid && i_out_stall, o_out_valid && $stable(r_mid_len))

endmodule

>>> hdl/vnu_front.sv
module vnu_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  vnu_pkg::t_in                i_data,
    output logic                        o_valid,
    output logic [vnu_pkg::RAD_W-1:0]   o_rad,
    output vnu_pkg::t_side              o_side
);
    import vnu_pkg::*;

    logic [5:0]                          r_vld;

    logic                                r_func;
    logic signed [IN_W-1:0]              r_a [LANES];
    logic signed [PROD_W-1:0]            r_p [2*LANES];

    logic signed [VEC_W-1:0]             r_v [LANES];
    logic signed [VEC_W-1:0]             n_v [LANES];
    logic signed [VEC_W-1:0]             n_negv [LANES];

    t_side                               r_side3;
    t_side                               n_side3;

    t_side                               r_side4;
    logic [PROD_W-1:0]                   r_ll [LANES];
    logic [PROD_W-1:0]                   r_hl [LANES];
    logic [PROD_W-1:0]                   r_hh [LANES];

    t_side                               r_side5;
    logic [SQ_W-1:0]                     r_sq [LANES];

    t_side                               r_side6;
    logic [RAD_W-1:0]                    r_rad;

    always_comb begin
        for (int j = 0; j < LANES; j++) begin
            if (r_func) begin
                n_v[j] = VEC_W'(r_p[2*j]) - VEC_W'(r_p[2*j+1]);
            end else begin
                n_v[j] = {{(VEC_W-IN_W-16){r_a[j][IN_W-1]}}, r_a[j], 16'b0};
            end
            n_negv[j] = -r_v[j];
            n_side3.neg[j] = r_v[j][VEC_W-1];
            n_side3.mag[j] = r_v[j][VEC_W-1] ? n_negv[j][MAG_W-1:0] : r_v[j][MAG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_func <= i_data.func;
            r_a[0] <= i_data.ax;
            r_a[1] <= i_data.ay;
            r_a[2] <= i_data.az;
            r_p[0] <= i_data.ay * i_data.bz;
            r_p[1] <= i_data.az * i_data.by;
            r_p[2] <= i_data.az * i_data.bx;
            r_p[3] <= i_data.ax * i_data.bz;
            r_p[4] <= i_data.ax * i_data.by;
            r_p[5] <= i_data.ay * i_data.bx;

            r_v <= n_v;

            r_side3 <= n_side3;

            r_side4 <= r_side3;
            for (int j = 0; j < LANES; j++) begin
                r_ll[j] <= r_side3.mag[j][HALF_W-1:0] * r_side3.mag[j][HALF_W-1:0];
                r_hl[j] <= r_side3.mag[j][MAG_W-1:HALF_W] * r_side3.mag[j][HALF_W-1:0];
                r_hh[j] <= r_side3.mag[j][MAG_W-1:HALF_W] * r_side3.mag[j][MAG_W-1:HALF_W];
            end

            r_side5 <= r_side4;
            for (int j = 0; j < LANES; j++) begin
                r_sq[j] <= {r_hh[j], {PROD_W{1'b0}}}
                         + {{(SQ_W-PROD_W-HALF_W-1){1'b0}}, r_hl[j], {(HALF_W+1){1'b0}}}
                         + {{(SQ_W-PROD_W){1'b0}}, r_ll[j]};
            end

            r_side6 <= r_side5;
            r_rad   <= {2'b00, r_sq[0]} + {2'b00, r_sq[1]} + {2'b00, r_sq[2]};
        end
    end

    assign o_valid = r_vld[5];
    assign o_rad   = r_rad;
    assign o_side  = r_side6;

endmodule

>>> hdl/vnu_sqrt.sv
module vnu_sqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [vnu_pkg::RAD_W-1:0]    i_rad,
    input  vnu_pkg::t_side               i_side,
    output logic                         o_valid,
    output logic [vnu_pkg::ROOT_W-1:0]   o_root,
    output vnu_pkg::t_side               o_side
);
    import vnu_pkg::*;

    logic                r_vld  [SQRT_STEPS];
    logic [RAD_W-1:0]    r_rad  [SQRT_STEPS];
    logic [REM_W-1:0]    r_rem  [SQRT_STEPS];
    logic [ROOT_W-1:0]   r_root [SQRT_STEPS];
    t_side               r_side [SQRT_STEPS];

    logic                n_vld  [SQRT_STEPS];
    logic [RAD_W-1:0]    n_rad  [SQRT_STEPS];
    logic [REM_W-1:0]    n_rem  [SQRT_STEPS];
    logic [ROOT_W-1:0]   n_root [SQRT_STEPS];
    t_side               n_side [SQRT_STEPS];

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
        logic                in_vld;
        logic [RAD_W-1:0]    in_rad;
        logic [REM_W-1:0]    in_rem;
        logic [ROOT_W-1:0]   in_root;
        t_side               in_side;
        logic [REM_W+1:0]    try_rem;
        logic [REM_W+1:0]    trial;
        logic [REM_W+1:0]    diff;
        logic                take;

        if (k == 0) begin : g_first
            assign in_vld  = i_valid;
            assign in_rad  = i_rad;
            assign in_rem  = '0;
            assign in_root = '0;
            assign in_side = i_side;
        end else begin : g_next
            assign in_vld  = r_vld[k-1];
            assign in_rad  = r_rad[k-1];
            assign in_rem  = r_rem[k-1];
            assign in_root = r_root[k-1];
            assign in_side = r_side[k-1];
        end

        assign try_rem   = {in_rem, in_rad[RAD_W-1 -: 2]};
        assign trial     = {1'b0, in_root, 2'b01};
        assign diff      = try_rem - trial;
        assign take      = (try_rem >= trial);
        assign n_vld[k]  = in_vld;
        assign n_rad[k]  = {in_rad[RAD_W-3:0], 2'b00};
        assign n_rem[k]  = take ? diff[REM_W-1:0] : try_rem[REM_W-1:0];
        assign n_root[k] = {in_root[ROOT_W-2:0], take};
        assign n_side[k] = in_side;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SQRT_STEPS; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (i_en) begin
            for (int k = 0; k < SQRT_STEPS; k++) begin
                r_vld[k] <= n_vld[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < SQRT_STEPS; k++) begin
                r_rad[k]  <= n_rad[k];
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                r_side[k] <= n_side[k];
            end
        end
    end

    assign o_valid = r_vld[SQRT_STEPS-1];
    assign o_root  = r_root[SQRT_STEPS-1];
    assign o_side  = r_side[SQRT_STEPS-1];

endmodule

>>> hdl/vnu_div.sv
module vnu_div (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_en,
    input  logic                                          i_valid,
    input  logic [vnu_pkg::ROOT_W-1:0]                    i_len,
    input  logic [vnu_pkg::LANES-1:0][vnu_pkg::MAG_W-1:0] i_mag,
    input  vnu_pkg::t_info                                i_info,
    output logic                                          o_valid,
    output logic [vnu_pkg::LANES-1:0][vnu_pkg::Q_W-1:0]   o_quo,
    output vnu_pkg::t_info                                o_info
);
    import vnu_pkg::*;

    logic                               r_vld  [DIV_STEPS];
    logic [ROOT_W-1:0]                  r_len  [DIV_STEPS];
    logic [LANES-1:0][ROOT_W-1:0]       r_rem  [DIV_STEPS];
    logic [LANES-1:0][Q_W-1:0]          r_quo  [DIV_STEPS];
    t_info                              r_info [DIV_STEPS];

    logic                               n_vld  [DIV_STEPS];
    logic [ROOT_W-1:0]                  n_len  [DIV_STEPS];
    logic [LANES-1:0][ROOT_W-1:0]       n_rem  [DIV_STEPS];
    logic [LANES-1:0][Q_W-1:0]          n_quo  [DIV_STEPS];
    t_info                              n_info [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic                           in_vld;
        logic [ROOT_W-1:0]              in_len;
        logic [LANES-1:0][ROOT_W:0]     rem_sh;
        logic [LANES-1:0][Q_W-1:0]      in_quo;
        t_info                          in_info;

        if (k == 0) begin : g_first
            assign in_vld  = i_valid;
            assign in_len  = i_len;
            assign in_quo  = '0;
            assign in_info = i_info;
            for (genvar j = 0; j < LANES; j++) begin : g_lane
                assign rem_sh[j] = {{(ROOT_W+1-MAG_W){1'b0}}, i_mag[j]};
            end
        end else begin : g_next
            assign in_vld  = r_vld[k-1];
            assign in_len  = r_len[k-1];
            assign in_quo  = r_quo[k-1];
            assign in_info = r_info[k-1];
            for (genvar j = 0; j < LANES; j++) begin : g_lane
                assign rem_sh[j] = {r_rem[k-1][j], 1'b0};
            end
        end

        for (genvar j = 0; j < LANES; j++) begin : g_calc
            logic [ROOT_W:0] diff;
            logic            ge;
            assign diff           = rem_sh[j] - {1'b0, in_len};
            assign ge             = (rem_sh[j] >= {1'b0, in_len});
            assign n_rem[k][j]    = ge ? diff[ROOT_W-1:0] : rem_sh[j][ROOT_W-1:0];
            assign n_quo[k][j]    = {in_quo[j][Q_W-2:0], ge};
        end

        assign n_vld[k]  = in_vld;
        assign n_len[k]  = in_len;
        assign n_info[k] = in_info;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_STEPS; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (i_en) begin
            for (int k = 0; k < DIV_STEPS; k++) begin
                r_vld[k] <= n_vld[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < DIV_STEPS; k++) begin
                r_len[k]  <= n_len[k];
                r_rem[k]  <= n_rem[k];
                r_quo[k]  <= n_quo[k];
                r_info[k] <= n_info[k];
            end
        end
    end

    assign o_valid = r_vld[DIV_STEPS-1];
    assign o_quo   = r_quo[DIV_STEPS-1];
    assign o_info  = r_info[DIV_STEPS-1];

endmodule

>>> sim/vec3_normalize_unit_cross_core_tb.sv
`timescale 1ns / 100ps

module vec3_normalize_unit_cross_core_tb;
    import vnu_pkg::*;

    localparam int LATENCY     = 88;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic FUNC_NORM  = 1'b0;
    localparam logic FUNC_CROSS = 1'b1;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_in                  i_in_data;
    logic                 o_out_valid;
    logic                 i_out_stall;
    t_out                 o_out_data;
    logic                 i_cfg_we;
    logic [MIN_W-1:0]     i_cfg_wdata;

    t_out                 unit_q[$];
    logic [MIN_W-1:0]     min_len;
    int                   send_idle_pct;
    int                   recv_idle_pct;
    int                   hold_cycles;
    int                   mismatches;
    int                   cycles;

    vec3_normalize_unit_cross_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    function automatic logic [63:0] abs64(logic signed [63:0] v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic t_out normalize_vec(t_in x, logic [MIN_W-1:0] thr);
        logic signed [63:0] v[3];
        logic [63:0]        m[3];
        logic [127:0]       s;
        logic [127:0]       sq;
        logic [63:0]        root;
        logic [63:0]        cand;
        logic [32:0]        lq;
        logic [127:0]       q;
        t_out               r;
        if (x.func == FUNC_CROSS) begin
            v[0] = 64'(x.ay) * 64'(x.bz) - 64'(x.az) * 64'(x.by);
            v[1] = 64'(x.az) * 64'(x.bx) - 64'(x.ax) * 64'(x.bz);
            v[2] = 64'(x.ax) * 64'(x.by) - 64'(x.ay) * 64'(x.bx);
        end else begin
            v[0] = 64'(x.ax) <<< 16;
            v[1] = 64'(x.ay) <<< 16;
            v[2] = 64'(x.az) <<< 16;
        end
        s = '0;
        for (int i = 0; i < 3; i++) begin
            m[i] = abs64(v[i]);
            s += 128'(m[i]) * 128'(m[i]);
        end
        root = '0;
        for (int b = 49; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            sq = 128'(cand) * 128'(cand);
            if (sq <= s) root = cand;
        end
        lq = 33'(root >> 16);
        r = '0;
        if (lq <= 33'(thr)) begin
            r.degenerate = 1'b1;
            return r;
        end
        r.vec_length = lq;
        for (int i = 0; i < 3; i++) begin
            q = (128'(m[i]) << 30) / 128'(root);
            if (v[i] < 0) q = -q;
            case (i)
                0: r.ux = q[31:0];
                1: r.uy = q[31:0];
                default: r.uz = q[31:0];
            endcase
        end
        return r;
    endfunction

    task automatic send_vec(t_in x);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= x;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        unit_q.push_back(normalize_vec(x, min_len));
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (unit_q.size() > 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    task automatic write_min_len(logic [MIN_W-1:0] val);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        min_len = val;
    endtask

    function automatic logic signed [23:0] rand_comp();
        case ($urandom_range(5))
            0: return 24'(signed'($urandom_range(15)) - 8);
            1: return 24'(signed'($urandom_range(1 << 16)) - (1 << 15));
            2: return $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
            3: return 24'(signed'($urandom_range(1 << 12)) - (1 << 11));
            default: return 24'($urandom());
        endcase
    endfunction

    function automatic t_in rand_item();
        t_in x;
        x.func = 1'($urandom_range(1));
        x.ax = rand_comp();
        x.ay = rand_comp();
        x.az = rand_comp();
        x.bx = rand_comp();
        x.by = rand_comp();
        x.bz = rand_comp();
        if ($urandom_range(9) == 0) begin
            x.bx = x.ax;
            x.by = x.ay;
            x.bz = x.az;
        end
        if ($urandom_range(9) == 0) begin
            x.ay = '0;
            x.az = '0;
        end
        return x;
    endfunction

    function automatic t_in mk(logic f, int ax, int ay, int az, int bx, int by, int bz);
        t_in x;
        x.func = f;
        x.ax = 24'(ax);
        x.ay = 24'(ay);
        x.az = 24'(az);
        x.bx = 24'(bx);
        x.by = 24'(by);
        x.bz = 24'(bz);
        return x;
    endfunction

    task automatic test_directed();
        send_vec(mk(FUNC_NORM, 0, 0, 0, 5, 6, 7));
        send_vec(mk(FUNC_NORM, 1, 0, 0, 0, 0, 0));
        send_vec(mk(FUNC_NORM, 65536, 0, 0, 0, 0, 0));
        send_vec(mk(FUNC_NORM, 0, -65536, 0, 0, 0, 0));
        send_vec(mk(FUNC_NORM, 0, 0, 8388607, 0, 0, 0));
        send_vec(mk(FUNC_NORM, -8388608, -8388608, -8388608, -1, -1, -1));
        send_vec(mk(FUNC_NORM, 8388607, 8388607, 8388607, 0, 0, 0));
        send_vec(mk(FUNC_NORM, 3 << 16, 4 << 16, 0, 0, 0, 0));
        send_vec(mk(FUNC_CROSS, 65536, 0, 0, 0, 65536, 0));
        send_vec(mk(FUNC_CROSS, 0, 65536, 0, 65536, 0, 0));
        send_vec(mk(FUNC_CROSS, 12345, 678, -9, 12345, 678, -9));
        send_vec(mk(FUNC_CROSS, 0, 0, 0, 8388607, 8388607, 8388607));
        send_vec(mk(FUNC_CROSS, -8388608, 8388607, -8388608, 8388607, -8388608, 8388607));
        send_vec(mk(FUNC_CROSS, -8388608, 0, 0, 0, -8388608, 0));
        send_vec(mk(FUNC_CROSS, 8388607, -1, 1, -1, 8388607, -8388608));
        send_vec(mk(FUNC_CROSS, 1, 0, 0, 0, 1, 0));
        send_vec(mk(FUNC_CROSS, 256, 0, 0, 0, 256, 0));
    endtask

    task automatic test_random(int n);
        repeat (n) send_vec(rand_item());
    endtask

    task automatic test_threshold();
        write_min_len(16'hFFFF);
        send_vec(mk(FUNC_NORM, 65535 << 7, 0, 0, 0, 0, 0));
        send_vec(mk(FUNC_NORM, 8388607, 0, 0, 0, 0, 0));
        send_vec(mk(FUNC_NORM, 0, -(1 << 16), 0, 0, 0, 0));
        test_random(150);
        write_min_len(16'd1);
        send_vec(mk(FUNC_NORM, 1, 0, 0, 0, 0, 0));
        send_vec(mk(FUNC_NORM, 2, 0, 0, 0, 0, 0));
        test_random(150);
        write_min_len(16'($urandom_range(16'hFFFF)));
        test_random(150);
        write_min_len(16'd0);
    endtask

    task automatic test_backpressure();
        hold_cycles = 300;
        test_random(150);
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_cycles > 0) begin
            i_out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_out_stall <= recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct;
        end
    end

    always @(posedge i_clk) begin
        t_out exp_r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (unit_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected transaction %p", o_out_data);
            end else begin
                exp_r = unit_q.pop_front();
                if (o_out_data.ux !== exp_r.ux || o_out_data.uy !== exp_r.uy
                        || o_out_data.uz !== exp_r.uz
                        || o_out_data.vec_length !== exp_r.vec_length
                        || o_out_data.degenerate !== exp_r.degenerate) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", exp_r, o_out_data);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_data     = '0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        min_len       = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles   = 0;
        mismatches    = 0;
        cycles        = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        write_min_len(16'd0);
        test_directed();
        send_idle_pct = 21;
        recv_idle_pct = 70;
        test_random(400);
        test_threshold();
        send_idle_pct = 70;
        recv_idle_pct = 21;
        test_random(400);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_backpressure();
        test_random(300);
        drain();
        if (mismatches == 0 && unit_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
